@@ rtl/core/rsw_pkg.sv @@
// ----------------------------------------------------------------------------
// rsw_pkg: shared types and constants of the seconds clock with two alarms
// Command codes, register indexes, default settings and the payload structs
// that pass between the request stage, the timekeeper and the response stage.
// ----------------------------------------------------------------------------
package rsw_pkg;

   // Default build settings
   localparam int WRAPS_PER_SECOND_DEF = 16;
   localparam int TICKS_PER_SECOND_DEF = 4096;

   // Fixed field widths
   localparam int CMD_W      = 2;
   localparam int DELAY_W    = 16;
   localparam int TICK_W     = 8;
   localparam int SIXT_W     = 4;
   localparam int SECONDS_W  = 32;
   localparam int FINE_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 1;

   // Scheduling units per second
   localparam int DELAY_UNITS_PER_SECOND = 1024;

   // Command codes
   typedef enum logic [CMD_W-1:0] {
      CMD_TICK    = 2'd0,
      CMD_SCHED_A = 2'd1,
      CMD_SCHED_B = 2'd2,
      CMD_READ    = 2'd3
   } cmd_type;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CLOCK_FAIL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_WAKE  = 2'd1;

   // One request transaction
   typedef struct packed {
      cmd_type              cmd;
      logic [DELAY_W-1:0]   delay_ms;
   } req_type;

   // One response transaction
   typedef struct packed {
      logic [FINE_W-1:0]    fine_time;
      logic [SECONDS_W-1:0] seconds_now;
      logic                 alarm_a_fired;
      logic                 alarm_b_fired;
      logic                 stay_awake;
   } rsp_type;

   // Register write carried to the timekeeper
   typedef struct packed {
      logic                  wr;
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } csr_wr_type;

endpackage

@@ rtl/core/rsw_req_stage.sv @@
// ----------------------------------------------------------------------------
// rsw_req_stage: request input register
// Captures one request transaction and holds it until the timekeeper
// processes it; takes the next one in the same cycle the current one leaves.
// ----------------------------------------------------------------------------
module rsw_req_stage
   import rsw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_req,
   input  logic    advance,
   output logic    held_valid,
   output req_type held_req
);

   logic    valid_ff;
   logic    valid_in;
   req_type req_ff;

   // Stage is free when empty or when its content moves on this cycle
   assign in_ready = !valid_ff || advance;
   assign valid_in = (in_valid && in_ready) || (valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         req_ff <= in_req;
      end
   end

   assign held_valid = valid_ff;
   assign held_req   = req_ff;

endmodule

@@ rtl/core/rsw_timekeeper.sv @@
// ----------------------------------------------------------------------------
// rsw_timekeeper: time counters, alarm state and settings registers
// Applies one request per enabled cycle to the tick, sixteenths and seconds
// counts and to both alarms, and forms the response from the new state.
// ----------------------------------------------------------------------------
module rsw_timekeeper
   import rsw_pkg::*;
#(
   parameter int WRAPS_PER_SECOND = WRAPS_PER_SECOND_DEF,
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  csr_wr_type csr,
   input  logic       en,
   input  req_type    req,
   output rsp_type    rsp
);

   localparam int          SCALE     = TICKS_PER_SECOND / DELAY_UNITS_PER_SECOND;
   localparam logic [15:0] SCALE_VEC = 16'(SCALE);
   localparam logic [4:0]  WRAP_LIM  = 5'(WRAPS_PER_SECOND);

   // Settings registers
   logic clock_fail_ff;
   logic slow_wake_ff;

   // Time and alarm state
   logic [TICK_W-1:0]    tick_ff,     tick_in;
   logic [SIXT_W-1:0]    sixt_ff,     sixt_in;
   logic [SECONDS_W-1:0] seconds_ff,  seconds_in;
   logic [7:0]           a_wraps_ff,  a_wraps_in;
   logic [7:0]           a_match_ff,  a_match_in;
   logic                 a_armed_ff,  a_armed_in;
   logic [7:0]           b_wraps_ff,  b_wraps_in;
   logic [7:0]           b_match_ff,  b_match_in;
   logic                 b_armed_ff,  b_armed_in;
   logic                 awake_ff,    awake_in;

   logic [DELAY_W-1:0]   target;
   logic [4:0]           sixt_sum;
   logic                 wrap;
   logic                 fired_a;
   logic                 fired_b;

   // Alarm target: current count plus the scaled delay, 16-bit wrap
   assign target = {8'd0, tick_ff} + 16'(req.delay_ms * SCALE_VEC);
   assign wrap     = (tick_ff == 8'hFF);
   assign sixt_sum = {1'b0, sixt_ff} + 5'd1;

   // Settings writes; indexes beyond the list are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_fail_ff <= 1'b0;
         slow_wake_ff  <= 1'b0;
      end else if (csr.wr) begin
         case (csr.index)
            CSR_CLOCK_FAIL: clock_fail_ff <= csr.data[0];
            CSR_SLOW_WAKE:  slow_wake_ff  <= csr.data[0];
            default: ;
         endcase
      end
   end

   // Next state and response for one request
   always_comb begin
      tick_in    = tick_ff;
      sixt_in    = sixt_ff;
      seconds_in = seconds_ff;
      a_wraps_in = a_wraps_ff;
      a_match_in = a_match_ff;
      a_armed_in = a_armed_ff;
      b_wraps_in = b_wraps_ff;
      b_match_in = b_match_ff;
      b_armed_in = b_armed_ff;
      awake_in   = awake_ff;
      fired_a    = 1'b0;
      fired_b    = 1'b0;
      unique case (req.cmd)
         CMD_TICK: begin
            tick_in = tick_ff + 8'd1;
            if (wrap) begin
               if (sixt_sum >= WRAP_LIM) begin
                  sixt_in    = '0;
                  seconds_in = seconds_ff + 32'd1;
               end else begin
                  sixt_in = sixt_sum[SIXT_W-1:0];
               end
               if (a_wraps_ff != 8'd0) begin
                  a_wraps_in = a_wraps_ff - 8'd1;
                  if (a_wraps_ff == 8'd1) begin
                     a_armed_in = 1'b1;
                  end
               end
               if (b_wraps_ff != 8'd0) begin
                  b_wraps_in = b_wraps_ff - 8'd1;
                  if (b_wraps_ff == 8'd1) begin
                     b_armed_in = 1'b1;
                  end
               end
            end
            // Compares are checked against the new count
            if (a_armed_in && (tick_in == a_match_ff)) begin
               a_armed_in = 1'b0;
               fired_a    = 1'b1;
            end
            if (b_armed_in && (tick_in == b_match_ff)) begin
               b_armed_in = 1'b0;
               fired_b    = 1'b1;
               awake_in   = 1'b0;
            end
         end
         CMD_SCHED_A: begin
            a_wraps_in = target[15:8];
            a_match_in = target[7:0];
            a_armed_in = (target[15:8] == 8'd0);
         end
         CMD_SCHED_B: begin
            if (clock_fail_ff) begin
               // With the clock failed, alarm B fires straight away
               fired_b  = 1'b1;
               awake_in = 1'b0;
            end else begin
               awake_in   = slow_wake_ff;
               b_wraps_in = target[15:8];
               b_match_in = target[7:0];
               b_armed_in = (target[15:8] == 8'd0);
            end
         end
         CMD_READ: begin
         end
      endcase
      rsp.fine_time     = {seconds_in[23:0], sixt_in, tick_in[7:4]};
      rsp.seconds_now   = seconds_in;
      rsp.alarm_a_fired = fired_a;
      rsp.alarm_b_fired = fired_b;
      rsp.stay_awake    = awake_in;
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff    <= '0;
         sixt_ff    <= '0;
         seconds_ff <= '0;
         a_wraps_ff <= '0;
         a_match_ff <= '0;
         a_armed_ff <= 1'b0;
         b_wraps_ff <= '0;
         b_match_ff <= '0;
         b_armed_ff <= 1'b0;
         awake_ff   <= 1'b0;
      end else if (en) begin
         tick_ff    <= tick_in;
         sixt_ff    <= sixt_in;
         seconds_ff <= seconds_in;
         a_wraps_ff <= a_wraps_in;
         a_match_ff <= a_match_in;
         a_armed_ff <= a_armed_in;
         b_wraps_ff <= b_wraps_in;
         b_match_ff <= b_match_in;
         b_armed_ff <= b_armed_in;
         awake_ff   <= awake_in;
      end
   end

   // Alarm A only fires on a tick
   assert property (@(posedge clock) disable iff (reset)
      en && rsp.alarm_a_fired |-> req.cmd == CMD_TICK)
      else $error("alarm A fired on a non-tick transaction");

   // A fired alarm is disarmed afterwards
   assert property (@(posedge clock) disable iff (reset)
      en && rsp.alarm_a_fired |=> !a_armed_ff)
      else $error("alarm A still armed after firing");

   // Alarm B firing always drops stay-awake
   assert property (@(posedge clock) disable iff (reset)
      en && rsp.alarm_b_fired |=> !awake_ff)
      else $error("stay-awake set after alarm B fired");

endmodule

@@ rtl/core/rsw_rsp_stage.sv @@
// ----------------------------------------------------------------------------
// rsw_rsp_stage: response output register
// Holds one finished response transaction until the consumer takes it and
// tells the upstream stage when a new response may be loaded.
// ----------------------------------------------------------------------------
module rsw_rsp_stage
   import rsw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   input  rsp_type in_rsp,
   output logic    load,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_rsp
);

   logic    valid_ff;
   logic    valid_in;
   rsp_type rsp_ff;

   // Load when empty or when the held response is taken this cycle
   assign load     = in_valid && (!valid_ff || out_ready);
   assign valid_in = load || (valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= in_rsp;
      end
   end

   assign out_valid = valid_ff;
   assign out_rsp   = rsp_ff;

endmodule

@@ rtl/core/rtc_seconds_with_two_alarms_core.sv @@
// ----------------------------------------------------------------------------
// rtc_seconds_with_two_alarms_core: seconds clock with two one-shot alarms
// Counts ticks into sixteenths and seconds, schedules and fires two alarms.
//
//   Channel  Direction  Handshake             Payload
//   req_     in         req_valid/req_ready   req_cmd, req_delay_ms
//   rsp_     out        rsp_valid/rsp_ready   fine_time, seconds_now, fired, awake
//   csr_     in         csr_valid/csr_ready   csr_index, csr_data
//
// One request per cycle sustained while rsp_ready is held high; an accepted
// request passes the request register, then the response register.
// Reset is synchronous and clears all counters, alarms and settings.
// A stalled response holds the timekeeper; the request register then fills
// and req_ready drops. csr_ready is always high.
// ----------------------------------------------------------------------------
module rtc_seconds_with_two_alarms_core
   import rsw_pkg::*;
#(
   parameter int WRAPS_PER_SECOND = WRAPS_PER_SECOND_DEF,
   parameter int TICKS_PER_SECOND = TICKS_PER_SECOND_DEF
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CMD_W-1:0]      req_cmd,
   input  logic [DELAY_W-1:0]    req_delay_ms,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FINE_W-1:0]     rsp_fine_time,
   output logic [SECONDS_W-1:0]  rsp_seconds_now,
   output logic                  rsp_alarm_a_fired,
   output logic                  rsp_alarm_b_fired,
   output logic                  rsp_stay_awake,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   req_type    in_req;
   req_type    held_req;
   logic       held_valid;
   logic       advance;
   rsp_type    next_rsp;
   rsp_type    out_rsp;
   csr_wr_type csr_wr;

   // Pack the ports into transaction structs
   assign in_req.cmd      = cmd_type'(req_cmd);
   assign in_req.delay_ms = req_delay_ms;

   assign csr_ready    = 1'b1;
   assign csr_wr.wr    = csr_valid;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   rsw_req_stage u_req (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_req     (in_req),
      .advance    (advance),
      .held_valid (held_valid),
      .held_req   (held_req)
   );

   rsw_timekeeper #(
      .WRAPS_PER_SECOND (WRAPS_PER_SECOND),
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
   ) u_time (
      .clock (clock),
      .reset (reset),
      .csr   (csr_wr),
      .en    (advance),
      .req   (held_req),
      .rsp   (next_rsp)
   );

   rsw_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (held_valid),
      .in_rsp    (next_rsp),
      .load      (advance),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_rsp   (out_rsp)
   );

   // Unpack the response transaction
   assign rsp_fine_time     = out_rsp.fine_time;
   assign rsp_seconds_now   = out_rsp.seconds_now;
   assign rsp_alarm_a_fired = out_rsp.alarm_a_fired;
   assign rsp_alarm_b_fired = out_rsp.alarm_b_fired;
   assign rsp_stay_awake    = out_rsp.stay_awake;

endmodule
